@@ rtl/core/ffpa_pkg.sv @@
// Shared types and constants for the first-fit pool allocator.
// No dependencies; imported by ffpa_walker and first_fit_pool_allocator.
package ffpa_pkg;

	localparam int CFG_W    = 13;
	localparam int ALLOC_W  = 13;
	localparam int OFFSET_W = 12;

	localparam logic [CFG_W-1:0] POOL_RESET = 13'd4096;

	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_NO_SPACE = 1'b1;

	typedef struct packed {
		logic                valid;
		logic                status;
		logic [OFFSET_W-1:0] offset;
	} res_t;

endpackage

@@ rtl/core/first_fit_pool_allocator.sv @@
// First-fit pool allocator top level: config register, output register, walker and header store.
// Depends on ffpa_pkg, ffpa_mem and ffpa_walker.
//
// Sequence: an accepted item reads header 0, then walks the block headers from the pool start
// in ST_WALK (one header read a cycle from the header store). A split adds ST_SPLIT for the
// second header write; a release of an allocated block adds ST_REL, which merges it with
// free neighbours from the neighbour read. The result waits in ST_DONE until the output
// register can take it; no new beat is taken before then. A null release skips the walk.
// After reset and after every pool_bytes write, s_axis_tready stays low until ST_INIT has
// written the first header. A new beat is taken while a result still waits in the output register.
module first_fit_pool_allocator
	import ffpa_pkg::*;
#(
	parameter int POOL_BYTES   = 4096,
	parameter int HEADER_BYTES = 16,
	parameter int SPLIT_SLACK  = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,      // pool_bytes
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [31:0]      s_axis_tdata,   // [12:0] alloc_bytes, [24:13] release_offset
	input  logic             s_axis_tuser,   // command
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // [11:0] payload_offset
	output logic             m_axis_tuser    // status
);

	localparam int LW = $clog2(POOL_BYTES + 1);
	localparam int AW = $clog2(POOL_BYTES);

	logic [CFG_W-1:0]    pool_q;
	logic [LW-1:0]       pool_size;
	res_t                res;
	logic                res_ready;
	logic                out_valid_q;
	logic                out_status_q;
	logic [OFFSET_W-1:0] out_off_q;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic [LW:0]         rd_data;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [LW:0]         wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= POOL_RESET;
		end else if (cfg_we) begin
			pool_q <= cfg_wdata;
		end
	end

	assign pool_size = (32'(pool_q) > 32'(POOL_BYTES)) ? LW'(POOL_BYTES) : LW'(pool_q);

	ffpa_walker #(
		.POOL_BYTES  (POOL_BYTES),
		.HEADER_BYTES(HEADER_BYTES),
		.SPLIT_SLACK (SPLIT_SLACK)
	) u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.pool_size(pool_size),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_cmd   (s_axis_tuser),
		.in_alloc (s_axis_tdata[ALLOC_W-1:0]),
		.in_off   (s_axis_tdata[ALLOC_W+OFFSET_W-1:ALLOC_W]),
		.res      (res),
		.res_ready(res_ready),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	ffpa_mem #(
		.DEPTH(POOL_BYTES),
		.DW   (LW + 1)
	) u_mem (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res.valid) begin
			out_status_q <= res.status;
			out_off_q    <= res.offset;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {(16 - OFFSET_W)'(0), out_off_q};

	a_no_accept_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !res.valid)
		else $error("input beat offered while a result is pending");

	a_no_space_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == STATUS_NO_SPACE) |-> (m_axis_tdata == '0))
		else $error("no_space result carries a non-zero offset");

	a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !s_axis_tready)
		else $error("beat taken before the pool was re-initialised");

endmodule

@@ rtl/core/ffpa_mem.sv @@
// Block header store: one write port, one read port, registered read data.
// No dependencies.
module ffpa_mem #(
	parameter int DEPTH = 4096,
	parameter int DW    = 14
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DW-1:0]            rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DW-1:0]            wr_data
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/core/ffpa_walker.sv @@
// Header walk sequencer: first-fit allocate with split, release with merge.
// Depends on ffpa_pkg; drives the ports of ffpa_mem.
module ffpa_walker
	import ffpa_pkg::*;
#(
	parameter int POOL_BYTES   = 4096,
	parameter int HEADER_BYTES = 16,
	parameter int SPLIT_SLACK  = 8,
	localparam int LW = $clog2(POOL_BYTES + 1),
	localparam int AW = $clog2(POOL_BYTES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [LW-1:0]       pool_size,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_cmd,
	input  logic [ALLOC_W-1:0]  in_alloc,
	input  logic [OFFSET_W-1:0] in_off,
	output res_t                res,
	input  logic                res_ready,
	output logic                rd_en,
	output logic [AW-1:0]       rd_addr,
	input  logic [LW:0]         rd_data,
	output logic                wr_en,
	output logic [AW-1:0]       wr_addr,
	output logic [LW:0]         wr_data
);

	localparam int AT_W = LW + 1;
	localparam int SW   = (LW + 2 > ALLOC_W + 2) ? LW + 2 : ALLOC_W + 2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_WALK,
		ST_SPLIT,
		ST_REL,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic                init_q;
	logic                cmd_q;
	logic [SW-1:0]       need_q;
	logic [OFFSET_W-1:0] off_q;
	logic [AT_W-1:0]     at_q;
	logic [AW-1:0]       prev_q;
	logic [LW-1:0]       prev_len_q;
	logic                prev_free_q;
	logic                has_prev_q;
	logic [LW-1:0]       cur_len_q;
	logic                nxt_ok_q;
	logic                res_status_q;
	logic [OFFSET_W-1:0] res_off_q;

	logic [LW-1:0]   rd_len;
	logic            rd_free;
	logic [SW-1:0]   at_ext;
	logic [SW-1:0]   len_ext;
	logic [SW-1:0]   rest;
	logic [SW-1:0]   hdr_end;
	logic [AT_W-1:0] at_nx;
	logic [LW-1:0]   nxt_len;
	logic [LW-1:0]   new_len;
	logic            walk_end;
	logic            fit;
	logic            split;
	logic            hit;
	logic            past;
	logic            next_in;
	logic            merge_prev;
	logic            accept;

	always_comb begin
		rd_len     = rd_data[LW-1:0];
		rd_free    = rd_data[LW];
		at_ext     = SW'(at_q);
		len_ext    = SW'(rd_len);
		walk_end   = (at_q >= AT_W'(pool_size)) || (rd_len == '0);
		fit        = rd_free && (len_ext >= need_q);
		rest       = at_ext + need_q;
		split      = (len_ext >= need_q + SW'(HEADER_BYTES + SPLIT_SLACK))
			&& (rest < SW'(POOL_BYTES));
		hdr_end    = at_ext + SW'(HEADER_BYTES);
		hit        = hdr_end == SW'(off_q);
		past       = hdr_end > SW'(off_q);
		at_nx      = at_q + AT_W'(rd_len);
		next_in    = at_nx < AT_W'(pool_size);
		nxt_len    = (nxt_ok_q && rd_free) ? rd_len : '0;
		new_len    = cur_len_q + nxt_len;
		merge_prev = has_prev_q && prev_free_q;
		accept     = (state_q == ST_IDLE) && !init_q && in_valid;
	end

	// read: header 0 on accept, then the following header on every walk beat
	always_comb begin
		rd_en   = accept || (state_q == ST_WALK);
		rd_addr = (state_q == ST_WALK) ? at_nx[AW-1:0] : '0;
		wr_en   = 1'b0;
		wr_addr = at_q[AW-1:0];
		wr_data = {1'b0, rd_len};
		case (state_q)
			ST_INIT: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = {1'b1, pool_size};
			end
			ST_WALK: begin
				if (cmd_q == CMD_ALLOC && !walk_end && fit) begin
					wr_en = 1'b1;
					if (split) begin
						wr_addr = rest[AW-1:0];
						wr_data = {1'b1, LW'(len_ext - need_q)};
					end
				end
			end
			ST_SPLIT: begin
				wr_en   = 1'b1;
				wr_data = {1'b0, need_q[LW-1:0]};
			end
			ST_REL: begin
				wr_en = 1'b1;
				if (merge_prev) begin
					wr_addr = prev_q;
					wr_data = {1'b1, LW'(prev_len_q + new_len)};
				end else begin
					wr_data = {1'b1, new_len};
				end
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			init_q       <= 1'b1;
			cmd_q        <= CMD_ALLOC;
			need_q       <= '0;
			off_q        <= '0;
			at_q         <= '0;
			prev_q       <= '0;
			prev_len_q   <= '0;
			prev_free_q  <= 1'b0;
			has_prev_q   <= 1'b0;
			cur_len_q    <= '0;
			nxt_ok_q     <= 1'b0;
			res_status_q <= STATUS_OK;
			res_off_q    <= '0;
		end else begin
			if (cfg_we) begin
				init_q <= 1'b1;
			end else if (state_q == ST_INIT) begin
				init_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (init_q) begin
						state_q <= ST_INIT;
					end else if (in_valid) begin
						cmd_q        <= in_cmd;
						need_q       <= SW'(in_alloc) + SW'(HEADER_BYTES);
						off_q        <= in_off;
						at_q         <= '0;
						has_prev_q   <= 1'b0;
						res_off_q    <= '0;
						res_status_q <= (in_cmd == CMD_ALLOC) ? STATUS_NO_SPACE : STATUS_OK;
						if (in_cmd == CMD_RELEASE && in_off == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_WALK;
						end
					end
				end
				ST_INIT: begin
					state_q <= ST_IDLE;
				end
				ST_WALK: begin
					if (walk_end) begin
						state_q <= ST_DONE;
					end else if (cmd_q == CMD_ALLOC) begin
						if (fit) begin
							res_status_q <= STATUS_OK;
							res_off_q    <= OFFSET_W'(hdr_end);
							state_q      <= split ? ST_SPLIT : ST_DONE;
						end else begin
							at_q <= at_nx;
						end
					end else if (hit) begin
						if (rd_free) begin
							state_q <= ST_DONE;
						end else begin
							cur_len_q <= rd_len;
							nxt_ok_q  <= next_in;
							state_q   <= ST_REL;
						end
					end else if (past) begin
						state_q <= ST_DONE;
					end else begin
						prev_q      <= at_q[AW-1:0];
						prev_len_q  <= rd_len;
						prev_free_q <= rd_free;
						has_prev_q  <= 1'b1;
						at_q        <= at_nx;
					end
				end
				ST_SPLIT: begin
					state_q <= ST_DONE;
				end
				ST_REL: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE) && !init_q;

	always_comb begin
		res.valid  = state_q == ST_DONE;
		res.status = res_status_q;
		res.offset = res_off_q;
	end

endmodule
